FILE: design/rvg_pkg.sv
// Shared constants, field widths and types of the radial vignetting gain block.
package rvg_pkg;

   // field and register widths
   localparam int COL_W      = 12;
   localparam int DIM_W      = 13;
   localparam int NS_W       = 24;
   localparam int NS_HALF    = 12;
   localparam int COEF_W     = 16;
   localparam int PIX_W      = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   // datapath widths
   localparam int D_W     = 15;              // 2*col - width, signed
   localparam int SQ_W    = 26;              // one squared offset
   localparam int SUM_W   = 27;              // sum of both squares
   localparam int FRAC_SH = 16;              // radicand scaling
   localparam int RAD_W   = 44;              // radicand, even width
   localparam int ROOT_W  = RAD_W / 2;       // square root
   localparam int MUL_W   = ROOT_W + NS_HALF;
   localparam int FULL_W  = ROOT_W + NS_W;
   localparam int R_W     = 17;              // radius, Q1.16
   localparam int R2_W    = 18;
   localparam int R3_W    = 19;
   localparam int R4_W    = 20;
   localparam int GAIN_W  = 38;              // gain, signed Q.30
   localparam int GMAG_W  = GAIN_W - 1;
   localparam int PROD_W  = PIX_W + GMAG_W;
   localparam int OUT_SH  = 30;

   // pipeline shape
   localparam int PRE_N      = 3;
   localparam int SQ_N       = ROOT_W;
   localparam int POST_N     = 9;
   localparam int PIPE_DEPTH = PRE_N + SQ_N + POST_N;

   // register reset values
   localparam logic [DIM_W-1:0]         RST_WIDTH   = 13'd100;
   localparam logic [DIM_W-1:0]         RST_HEIGHT  = 13'd100;
   localparam logic [NS_W-1:0]          RST_NORM    = 24'd118632;
   localparam logic signed [COEF_W-1:0] RST_COEF    = 16'sd0;
   localparam logic signed [COEF_W-1:0] RST_COEF_R0 = 16'sd16384;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH  = 3'd0,
      CSR_IMAGE_HEIGHT = 3'd1,
      CSR_NORM_SCALE   = 3'd2,
      CSR_COEF_R4      = 3'd3,
      CSR_COEF_R3      = 3'd4,
      CSR_COEF_R2      = 3'd5,
      CSR_COEF_R1      = 3'd6,
      CSR_COEF_R0      = 3'd7
   } csr_idx_type;

   // pixel data that rides along with the radius computation
   typedef struct packed {
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] blue;
      logic             frame_end;
   } side_type;

endpackage

FILE: design/rvg_if.sv
// Pixel request and response channel interfaces.
interface rvg_req_if import rvg_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [COL_W-1:0] column;
   logic [COL_W-1:0] row;
   logic [PIX_W-1:0] red;
   logic [PIX_W-1:0] green;
   logic [PIX_W-1:0] blue;

   modport source (output valid, column, row, red, green, blue, input ready);
   modport sink   (input valid, column, row, red, green, blue, output ready);
endinterface

interface rvg_rsp_if import rvg_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] out_red;
   logic [PIX_W-1:0] out_green;
   logic [PIX_W-1:0] out_blue;
   logic             frame_end;

   modport source (output valid, out_red, out_green, out_blue, frame_end, input ready);
   modport sink   (input valid, out_red, out_green, out_blue, frame_end, output ready);
endinterface

FILE: design/rvg_sqrt.sv
// Pipelined integer square root, one result bit per stage.
module rvg_sqrt import rvg_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic [SQ_N-1:0]   stage_en,
   input  logic              in_vld,
   input  logic [RAD_W-1:0]  in_rad,
   input  side_type          in_side,
   output logic [SQ_N-1:0]   stage_vld,
   output logic [ROOT_W-1:0] out_root,
   output side_type          out_side
);

   logic [SQ_N-1:0]   vld_ff;
   logic [SQ_N-1:0]   prev_vld;
   logic [ROOT_W-1:0] root_ff [SQ_N];
   side_type          side_ff [SQ_N];
   logic [ROOT_W-1:0] rem_ff  [SQ_N-1];
   logic [RAD_W-1:0]  rad_ff  [SQ_N-1];

   assign prev_vld = {vld_ff[SQ_N-2:0], in_vld};

   // valid bits move with their beat
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < SQ_N; k++) begin
            if (stage_en[k]) begin
               vld_ff[k] <= prev_vld[k];
            end
         end
      end
   end

   // one restoring step per stage: bring down two radicand bits, try root*4+1
   for (genvar k = 0; k < SQ_N; k++) begin : g_step
      logic [ROOT_W-1:0] p_rem;
      logic [ROOT_W-1:0] p_root;
      logic [RAD_W-1:0]  p_rad;
      side_type          p_side;
      logic [ROOT_W+1:0] rem_sh;
      logic [ROOT_W+1:0] trial;
      logic [ROOT_W+1:0] rem_in;
      logic [ROOT_W-1:0] root_in;
      logic              fit;

      if (k == 0) begin : g_first
         assign p_rem  = '0;
         assign p_root = '0;
         assign p_rad  = in_rad;
         assign p_side = in_side;
      end else begin : g_next
         assign p_rem  = rem_ff[k-1];
         assign p_root = root_ff[k-1];
         assign p_rad  = rad_ff[k-1];
         assign p_side = side_ff[k-1];
      end

      assign rem_sh  = {p_rem, p_rad[RAD_W-1 -: 2]};
      assign trial   = {p_root, 2'b01};
      assign fit     = (rem_sh >= trial);
      assign rem_in  = fit ? (rem_sh - trial) : rem_sh;
      assign root_in = {p_root[ROOT_W-2:0], fit};

      always_ff @(posedge clock) begin
         if (stage_en[k]) begin
            root_ff[k] <= root_in;
            side_ff[k] <= p_side;
         end
      end

      // remainder stays below 2^ROOT_W until the final step
      if (k < SQ_N - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (stage_en[k]) begin
               rem_ff[k] <= rem_in[ROOT_W-1:0];
               rad_ff[k] <= {p_rad[RAD_W-3:0], 2'b00};
            end
         end
      end
   end

   assign stage_vld = vld_ff;
   assign out_root  = root_ff[SQ_N-1];
   assign out_side  = side_ff[SQ_N-1];

endmodule

FILE: design/radial_vignetting_gain_top.sv
// Radial vignetting gain: per-pixel quartic gain from distance to the frame center.
//
// The block takes one pixel beat per clock while the response side keeps up and
// returns one corrected pixel per beat, in order. The pipeline has 3 stages that
// form the squared distance, 22 stages that produce the square root one bit each,
// and 9 stages that scale the radius, build the polynomial and apply the gain.
// Every stage holds its beat while the response side stalls, and an empty stage
// still takes a new beat, so req_ch.ready stays high until every stage is occupied.
// Register writes take effect at once and are meant for times when no beat is
// in flight.
module radial_vignetting_gain_top import rvg_pkg::*; #(
   parameter int MAX_DIM = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   rvg_req_if.sink               req_ch,
   rvg_rsp_if.source             rsp_ch,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int DIM_MAX = (1 << DIM_W) - 1;
   localparam int DIM_CAP = (MAX_DIM > DIM_MAX) ? DIM_MAX : MAX_DIM;
   localparam logic [DIM_W-1:0] DIM_CAP_V = DIM_W'(DIM_CAP);

   localparam int SQ_BEG   = PRE_N;
   localparam int SQ_END   = PRE_N + SQ_N - 1;
   localparam int POST_BEG = SQ_END + 1;
   localparam int LAST     = PIPE_DEPTH - 1;

   localparam int T4_W = COEF_W + R4_W + 1;
   localparam int T3_W = COEF_W + R3_W + 1;
   localparam int T2_W = COEF_W + R2_W + 1;
   localparam int T1_W = COEF_W + R_W + 1;
   localparam int T0_W = COEF_W + FRAC_SH;

   // ---------------------------------------------------------------- registers
   logic [DIM_W-1:0]         width_ff;
   logic [DIM_W-1:0]         height_ff;
   logic [NS_W-1:0]          norm_ff;
   logic signed [COEF_W-1:0] coef_r4_ff;
   logic signed [COEF_W-1:0] coef_r3_ff;
   logic signed [COEF_W-1:0] coef_r2_ff;
   logic signed [COEF_W-1:0] coef_r1_ff;
   logic signed [COEF_W-1:0] coef_r0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= RST_WIDTH;
         height_ff  <= RST_HEIGHT;
         norm_ff    <= RST_NORM;
         coef_r4_ff <= RST_COEF;
         coef_r3_ff <= RST_COEF;
         coef_r2_ff <= RST_COEF;
         coef_r1_ff <= RST_COEF;
         coef_r0_ff <= RST_COEF_R0;
      end else if (csr_wr_en) begin
         unique case (csr_idx_type'(csr_index))
            CSR_IMAGE_WIDTH:  width_ff   <= csr_wdata[DIM_W-1:0];
            CSR_IMAGE_HEIGHT: height_ff  <= csr_wdata[DIM_W-1:0];
            CSR_NORM_SCALE:   norm_ff    <= csr_wdata[NS_W-1:0];
            CSR_COEF_R4:      coef_r4_ff <= csr_wdata[COEF_W-1:0];
            CSR_COEF_R3:      coef_r3_ff <= csr_wdata[COEF_W-1:0];
            CSR_COEF_R2:      coef_r2_ff <= csr_wdata[COEF_W-1:0];
            CSR_COEF_R1:      coef_r1_ff <= csr_wdata[COEF_W-1:0];
            CSR_COEF_R0:      coef_r0_ff <= csr_wdata[COEF_W-1:0];
         endcase
      end
   end

   // ---------------------------------------------------------------- flow control
   logic [PRE_N-1:0]      pre_vld_ff;
   logic [POST_N-1:0]     post_vld_ff;
   logic [SQ_N-1:0]       sq_vld;
   logic [PIPE_DEPTH-1:0] vld;
   logic [PIPE_DEPTH-1:0] prev_vld;
   logic [PIPE_DEPTH-1:0] en;

   assign vld      = {post_vld_ff, sq_vld, pre_vld_ff};
   assign prev_vld = {vld[PIPE_DEPTH-2:0], req_ch.valid};

   // a stage loads when it is empty or its beat moves on
   for (genvar i = 0; i < PIPE_DEPTH; i++) begin : g_en
      if (i == LAST) begin : g_tail
         assign en[i] = !vld[i] || rsp_ch.ready;
      end else begin : g_body
         assign en[i] = !vld[i] || en[i+1];
      end
   end

   assign req_ch.ready = en[0];
   assign rsp_ch.valid = vld[LAST];

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_vld_ff  <= '0;
         post_vld_ff <= '0;
      end else begin
         for (int i = 0; i < PRE_N; i++) begin
            if (en[i]) begin
               pre_vld_ff[i] <= prev_vld[i];
            end
         end
         for (int k = 0; k < POST_N; k++) begin
            if (en[POST_BEG+k]) begin
               post_vld_ff[k] <= prev_vld[POST_BEG+k];
            end
         end
      end
   end

   // ---------------------------------------------------------------- stage 0: offsets
   logic [DIM_W-1:0]    w_eff;
   logic [DIM_W-1:0]    h_eff;
   logic signed [D_W-1:0] dx_in;
   logic signed [D_W-1:0] dy_in;
   logic                fe_in;
   side_type            side0_in;
   logic signed [D_W-1:0] dx_ff;
   logic signed [D_W-1:0] dy_ff;
   side_type            side0_ff;

   assign w_eff = (width_ff > DIM_CAP_V) ? DIM_CAP_V : width_ff;
   assign h_eff = (height_ff > DIM_CAP_V) ? DIM_CAP_V : height_ff;
   assign dx_in = $signed({2'b00, req_ch.column, 1'b0}) - $signed({2'b00, w_eff});
   assign dy_in = $signed({2'b00, req_ch.row, 1'b0}) - $signed({2'b00, h_eff});
   assign fe_in = (({1'b0, req_ch.column} + DIM_W'(1)) == w_eff)
               && (({1'b0, req_ch.row} + DIM_W'(1)) == h_eff);

   always_comb begin
      side0_in.red       = req_ch.red;
      side0_in.green     = req_ch.green;
      side0_in.blue      = req_ch.blue;
      side0_in.frame_end = fe_in;
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         dx_ff    <= dx_in;
         dy_ff    <= dy_in;
         side0_ff <= side0_in;
      end
   end

   // ---------------------------------------------------------------- stage 1: squares
   logic signed [2*D_W-1:0] dx_sq;
   logic signed [2*D_W-1:0] dy_sq;
   logic [SQ_W-1:0]         dx2_ff;
   logic [SQ_W-1:0]         dy2_ff;
   side_type                side1_ff;

   assign dx_sq = dx_ff * dx_ff;
   assign dy_sq = dy_ff * dy_ff;

   always_ff @(posedge clock) begin
      if (en[1]) begin
         dx2_ff   <= dx_sq[SQ_W-1:0];
         dy2_ff   <= dy_sq[SQ_W-1:0];
         side1_ff <= side0_ff;
      end
   end

   // ---------------------------------------------------------------- stage 2: radicand
   logic [SUM_W-1:0] sq_sum;
   logic [RAD_W-1:0] rad_ff;
   side_type         side2_ff;

   assign sq_sum = {1'b0, dx2_ff} + {1'b0, dy2_ff};

   always_ff @(posedge clock) begin
      if (en[2]) begin
         rad_ff   <= {{(RAD_W-SUM_W-FRAC_SH){1'b0}}, sq_sum, {FRAC_SH{1'b0}}};
         side2_ff <= side1_ff;
      end
   end

   // ---------------------------------------------------------------- square root
   logic [ROOT_W-1:0] root;
   side_type          sq_side;

   rvg_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .stage_en  (en[SQ_END:SQ_BEG]),
      .in_vld    (vld[PRE_N-1]),
      .in_rad    (rad_ff),
      .in_side   (side2_ff),
      .stage_vld (sq_vld),
      .out_root  (root),
      .out_side  (sq_side)
   );

   // ---------------------------------------------------------------- P0: scale, split
   logic [MUL_W-1:0] ph_ff;
   logic [MUL_W-1:0] pl_ff;
   side_type         p0_side_ff;

   always_ff @(posedge clock) begin
      if (en[POST_BEG]) begin
         ph_ff      <= root * norm_ff[NS_W-1:NS_HALF];
         pl_ff      <= root * norm_ff[NS_HALF-1:0];
         p0_side_ff <= sq_side;
      end
   end

   // ---------------------------------------------------------------- P1: radius, saturated
   logic [FULL_W-1:0]         full_prod;
   logic [FULL_W-FRAC_SH-1:0] r_full;
   logic [R_W-1:0]            r_sat;
   logic [R_W-1:0]            r_ff;
   side_type                  p1_side_ff;

   assign full_prod = {ph_ff, {NS_HALF{1'b0}}} + {{NS_HALF{1'b0}}, pl_ff};
   assign r_full    = full_prod[FULL_W-1:FRAC_SH];
   assign r_sat     = (|r_full[FULL_W-FRAC_SH-1:R_W]) ? '1 : r_full[R_W-1:0];

   always_ff @(posedge clock) begin
      if (en[POST_BEG+1]) begin
         r_ff       <= r_sat;
         p1_side_ff <= p0_side_ff;
      end
   end

   // ---------------------------------------------------------------- P2: r^2
   logic [2*R_W-1:0] r_sq;
   logic [R_W-1:0]   r_p2_ff;
   logic [R2_W-1:0]  r2_ff;
   side_type         p2_side_ff;

   assign r_sq = r_ff * r_ff;

   always_ff @(posedge clock) begin
      if (en[POST_BEG+2]) begin
         r_p2_ff    <= r_ff;
         r2_ff      <= r_sq[2*R_W-1:FRAC_SH];
         p2_side_ff <= p1_side_ff;
      end
   end

   // ---------------------------------------------------------------- P3: r^3 and r^4
   logic [R2_W+R_W-1:0] r3_prod;
   logic [2*R2_W-1:0]   r4_prod;
   logic [R_W-1:0]      r_p3_ff;
   logic [R2_W-1:0]     r2_p3_ff;
   logic [R3_W-1:0]     r3_ff;
   logic [R4_W-1:0]     r4_ff;
   side_type            p3_side_ff;

   assign r3_prod = r2_ff * r_p2_ff;
   assign r4_prod = r2_ff * r2_ff;

   always_ff @(posedge clock) begin
      if (en[POST_BEG+3]) begin
         r_p3_ff    <= r_p2_ff;
         r2_p3_ff   <= r2_ff;
         r3_ff      <= r3_prod[R2_W+R_W-1:FRAC_SH];
         r4_ff      <= r4_prod[2*R2_W-1:FRAC_SH];
         p3_side_ff <= p2_side_ff;
      end
   end

   // ---------------------------------------------------------------- P4: terms
   logic signed [R4_W:0]   r4_s;
   logic signed [R3_W:0]   r3_s;
   logic signed [R2_W:0]   r2_s;
   logic signed [R_W:0]    r1_s;
   logic signed [T4_W-1:0] t4_ff;
   logic signed [T3_W-1:0] t3_ff;
   logic signed [T2_W-1:0] t2_ff;
   logic signed [T1_W-1:0] t1_ff;
   logic signed [T0_W-1:0] t0_ff;
   side_type               p4_side_ff;

   assign r4_s = $signed({1'b0, r4_ff});
   assign r3_s = $signed({1'b0, r3_ff});
   assign r2_s = $signed({1'b0, r2_p3_ff});
   assign r1_s = $signed({1'b0, r_p3_ff});

   always_ff @(posedge clock) begin
      if (en[POST_BEG+4]) begin
         t4_ff      <= coef_r4_ff * r4_s;
         t3_ff      <= coef_r3_ff * r3_s;
         t2_ff      <= coef_r2_ff * r2_s;
         t1_ff      <= coef_r1_ff * r1_s;
         t0_ff      <= {coef_r0_ff, {FRAC_SH{1'b0}}};
         p4_side_ff <= p3_side_ff;
      end
   end

   // ---------------------------------------------------------------- P5: partial sums
   logic signed [GAIN_W-1:0] sa_ff;
   logic signed [GAIN_W-1:0] sb_ff;
   logic signed [T0_W-1:0]   t0_p5_ff;
   side_type                 p5_side_ff;

   always_ff @(posedge clock) begin
      if (en[POST_BEG+5]) begin
         sa_ff      <= {{(GAIN_W-T4_W){t4_ff[T4_W-1]}}, t4_ff}
                     + {{(GAIN_W-T3_W){t3_ff[T3_W-1]}}, t3_ff};
         sb_ff      <= {{(GAIN_W-T2_W){t2_ff[T2_W-1]}}, t2_ff}
                     + {{(GAIN_W-T1_W){t1_ff[T1_W-1]}}, t1_ff};
         t0_p5_ff   <= t0_ff;
         p5_side_ff <= p4_side_ff;
      end
   end

   // ---------------------------------------------------------------- P6: gain
   logic signed [GAIN_W-1:0] gain_ff;
   side_type                 p6_side_ff;

   always_ff @(posedge clock) begin
      if (en[POST_BEG+6]) begin
         gain_ff    <= sa_ff + sb_ff + {{(GAIN_W-T0_W){t0_p5_ff[T0_W-1]}}, t0_p5_ff};
         p6_side_ff <= p5_side_ff;
      end
   end

   // ---------------------------------------------------------------- P7: apply gain
   // a negative gain is forced to zero so every channel comes out as zero
   logic [GMAG_W-1:0] gmag;
   logic [PROD_W-1:0] pr_ff;
   logic [PROD_W-1:0] pg_ff;
   logic [PROD_W-1:0] pb_ff;
   logic              fe_p7_ff;

   assign gmag = gain_ff[GAIN_W-1] ? '0 : gain_ff[GMAG_W-1:0];

   always_ff @(posedge clock) begin
      if (en[POST_BEG+7]) begin
         pr_ff    <= p6_side_ff.red * gmag;
         pg_ff    <= p6_side_ff.green * gmag;
         pb_ff    <= p6_side_ff.blue * gmag;
         fe_p7_ff <= p6_side_ff.frame_end;
      end
   end

   // ---------------------------------------------------------------- P8: clamp, output
   logic [PIX_W-1:0] red_ff;
   logic [PIX_W-1:0] green_ff;
   logic [PIX_W-1:0] blue_ff;
   logic             fe_ff;

   function automatic logic [PIX_W-1:0] clamp_pix(input logic [PROD_W-1:0] p);
      clamp_pix = (|p[PROD_W-1:OUT_SH+PIX_W]) ? '1 : p[OUT_SH+PIX_W-1:OUT_SH];
   endfunction

   always_ff @(posedge clock) begin
      if (en[LAST]) begin
         red_ff   <= clamp_pix(pr_ff);
         green_ff <= clamp_pix(pg_ff);
         blue_ff  <= clamp_pix(pb_ff);
         fe_ff    <= fe_p7_ff;
      end
   end

   assign rsp_ch.out_red   = red_ff;
   assign rsp_ch.out_green = green_ff;
   assign rsp_ch.out_blue  = blue_ff;
   assign rsp_ch.frame_end = fe_ff;

endmodule

FILE: design/rvg_checker.sv
// Port-level checks for the radial vignetting gain block, bound to the top level.
module rvg_checker import rvg_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [PIX_W-1:0] out_red,
   input logic [PIX_W-1:0] out_green,
   input logic [PIX_W-1:0] out_blue,
   input logic             frame_end
);

   localparam int CNT_W = $clog2(PIPE_DEPTH + 2);

   logic             req_acc;
   logic             rsp_acc;
   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] cnt_in;

   assign req_acc = req_valid && req_ready;
   assign rsp_acc = rsp_valid && rsp_ready;
   assign cnt_in  = cnt_ff + CNT_W'(req_acc) - CNT_W'(rsp_acc);

   // beats taken but not yet delivered
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response beat dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable({out_red, out_green, out_blue, frame_end}))
      else $error("response payload changed while stalled");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> cnt_ff != '0)
      else $error("response beat without a request beat in flight");

   a_bounded: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(PIPE_DEPTH))
      else $error("more beats in flight than pipeline stages");

   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled while output stage is empty");

endmodule

bind radial_vignetting_gain_top rvg_checker u_rvg_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .out_red   (rsp_ch.out_red),
   .out_green (rsp_ch.out_green),
   .out_blue  (rsp_ch.out_blue),
   .frame_end (rsp_ch.frame_end)
);

FILE: verif/rvg_pixel_checker.sv
// Scoreboard for the radial vignetting gain block: predicts each corrected pixel and compares.
module rvg_pixel_checker import rvg_pkg::*; #(
   parameter int MAX_DIM = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   rvg_req_if                    req_ch,
   rvg_rsp_if                    rsp_ch,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    fail_count,
   output int                    pending
);

   typedef longint unsigned u64_t;

   localparam int   RADIUS_FRAC = 16;
   localparam int   GAIN_FRAC   = 30;
   localparam u64_t RADIUS_SAT  = 64'd131071;   // just under 2.0 in Q1.16
   localparam int   MAX_REPORTS = 10;
   localparam logic [PIX_W-1:0] PIX_MAX = '1;

   // local copy of the register file
   logic [DIM_W-1:0]         width_q;
   logic [DIM_W-1:0]         height_q;
   logic [NS_W-1:0]          scale_q;
   logic signed [COEF_W-1:0] coef_q [0:4];     // index is the power of r

   side_type expected_pixels [$];
   int       mismatches = 0;

   // floor square root, built one result bit at a time from the top
   function automatic u64_t root_floor(input u64_t x);
      u64_t acc;
      u64_t trial;
      acc = 0;
      for (int b = 21; b >= 0; b--) begin
         trial = acc | (u64_t'(1) << b);
         if (trial * trial <= x)
            acc = trial;
      end
      return acc;
   endfunction

   // channel times Q.30 gain, truncated, clamped to the pixel range
   function automatic logic [PIX_W-1:0] gained_channel(input logic [PIX_W-1:0] sample,
                                                       input longint gain);
      longint prod;
      prod = longint'(sample) * gain;
      if (prod <= 0)
         return '0;
      prod = prod >>> GAIN_FRAC;
      return (prod > longint'(PIX_MAX)) ? PIX_MAX : prod[PIX_W-1:0];
   endfunction

   function automatic side_type corrected_pixel(input logic [COL_W-1:0] col,
                                                input logic [COL_W-1:0] row,
                                                input logic [PIX_W-1:0] red,
                                                input logic [PIX_W-1:0] green,
                                                input logic [PIX_W-1:0] blue);
      longint   eff_w, eff_h, dx, dy, dist_sq, gain;
      u64_t     root, radius, rad2, rad3, rad4;
      side_type res;
      // oversized frames are held at the maximum dimension
      eff_w = (width_q > MAX_DIM) ? MAX_DIM : longint'(width_q);
      eff_h = (height_q > MAX_DIM) ? MAX_DIM : longint'(height_q);
      // twice the offset from the center, so the center stays exact
      dx = 2 * longint'(col) - eff_w;
      dy = 2 * longint'(row) - eff_h;
      dist_sq = dx * dx + dy * dy;
      root = root_floor(u64_t'(dist_sq) << RADIUS_FRAC);
      radius = (root * u64_t'(scale_q)) >> RADIUS_FRAC;
      if (radius > RADIUS_SAT)
         radius = RADIUS_SAT;
      rad2 = (radius * radius) >> RADIUS_FRAC;
      rad3 = (rad2 * radius) >> RADIUS_FRAC;
      rad4 = (rad2 * rad2) >> RADIUS_FRAC;
      gain = longint'(coef_q[4]) * longint'(rad4)
           + longint'(coef_q[3]) * longint'(rad3)
           + longint'(coef_q[2]) * longint'(rad2)
           + longint'(coef_q[1]) * longint'(radius)
           + longint'(coef_q[0]) * (longint'(1) << RADIUS_FRAC);
      res.red       = gained_channel(red, gain);
      res.green     = gained_channel(green, gain);
      res.blue      = gained_channel(blue, gain);
      res.frame_end = (longint'(col) + 1 == eff_w) && (longint'(row) + 1 == eff_h);
      return res;
   endfunction

   always @(posedge clock) begin
      side_type want;
      side_type got;
      if (reset) begin
         width_q  = RST_WIDTH;
         height_q = RST_HEIGHT;
         scale_q  = RST_NORM;
         coef_q[4] = RST_COEF;
         coef_q[3] = RST_COEF;
         coef_q[2] = RST_COEF;
         coef_q[1] = RST_COEF;
         coef_q[0] = RST_COEF_R0;
         expected_pixels.delete();
      end else begin
         // result beat: check against the oldest prediction
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.red       = rsp_ch.out_red;
            got.green     = rsp_ch.out_green;
            got.blue      = rsp_ch.out_blue;
            got.frame_end = rsp_ch.frame_end;
            if (expected_pixels.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("unexpected pixel beat: r=%0d g=%0d b=%0d end=%0b",
                           got.red, got.green, got.blue, got.frame_end);
            end else begin
               want = expected_pixels.pop_front();
               if (got.red !== want.red || got.green !== want.green ||
                   got.blue !== want.blue || got.frame_end !== want.frame_end) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS)
                     $display("mismatch: want %0d/%0d/%0d end=%0b, got %0d/%0d/%0d end=%0b",
                              want.red, want.green, want.blue, want.frame_end,
                              got.red, got.green, got.blue, got.frame_end);
               end
            end
         end
         // request beat: predict its corrected pixel
         if (req_ch.valid && req_ch.ready)
            expected_pixels.insert(expected_pixels.size(),
                                   corrected_pixel(req_ch.column, req_ch.row,
                                                   req_ch.red, req_ch.green, req_ch.blue));
         // register writes land at this edge
         if (csr_wr_en) begin
            case (csr_index)
               CSR_IMAGE_WIDTH:  width_q   = csr_wdata[DIM_W-1:0];
               CSR_IMAGE_HEIGHT: height_q  = csr_wdata[DIM_W-1:0];
               CSR_NORM_SCALE:   scale_q   = csr_wdata[NS_W-1:0];
               CSR_COEF_R4:      coef_q[4] = csr_wdata[COEF_W-1:0];
               CSR_COEF_R3:      coef_q[3] = csr_wdata[COEF_W-1:0];
               CSR_COEF_R2:      coef_q[2] = csr_wdata[COEF_W-1:0];
               CSR_COEF_R1:      coef_q[1] = csr_wdata[COEF_W-1:0];
               CSR_COEF_R0:      coef_q[0] = csr_wdata[COEF_W-1:0];
            endcase
         end
      end
      pending    <= expected_pixels.size();
      fail_count <= mismatches;
   end

endmodule

FILE: verif/tb_radial_vignetting_gain_top.sv
// Testbench top for the radial vignetting gain block: stimulus, idling, watchdog and verdict.
module tb_radial_vignetting_gain_top;
   import rvg_pkg::*;

   localparam int MAX_DIM       = 4096;
   localparam int STALL_PCT     = 31;
   localparam int IDLE_LIMIT    = 2000;
   localparam int RANDOM_PIXELS = 1250;
   localparam int PHASES        = 10;
   localparam int STEADY_PHASE  = 4;
   localparam int NS_SPAN       = (1 << NS_W) - 1;
   localparam logic [COEF_W-1:0] COEF_ONE     = 16'h4000;
   localparam logic [COEF_W-1:0] COEF_NEG_ONE = 16'hC000;
   localparam logic [COEF_W-1:0] COEF_ZERO    = 16'h0000;

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   logic                  steady;
   int                    fail_count;
   int                    pending;
   int                    idle_cycles = 0;

   rvg_req_if req_ch ();
   rvg_rsp_if rsp_ch ();

   radial_vignetting_gain_top #(.MAX_DIM(MAX_DIM)) uut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   rvg_pixel_checker #(.MAX_DIM(MAX_DIM)) pixel_check (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // response side back-pressure
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         rsp_ch.ready <= steady || ($urandom_range(99) >= STALL_PCT);
      end
   end

   // watchdog: cycles with no beat on either channel
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb_radial_vignetting_gain_top NOT OK");
         $finish;
      end
   end

   // one pixel beat; valid stays high on return
   task automatic send_pixel(input logic [COL_W-1:0] col, input logic [COL_W-1:0] row,
                             input logic [PIX_W-1:0] red, input logic [PIX_W-1:0] green,
                             input logic [PIX_W-1:0] blue);
      while (!steady && $urandom_range(99) < STALL_PCT) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.column <= col;
      req_ch.row    <= row;
      req_ch.red    <= red;
      req_ch.green  <= green;
      req_ch.blue   <= blue;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
   endtask

   // junk above the register width must be dropped by the block
   task automatic write_csr(input csr_idx_type idx, input logic [CSR_DATA_W-1:0] data,
                            input int bits);
      logic [31:0] junk;
      junk = $urandom;
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(junk << bits) | data;
      @(posedge clock);
   endtask

   task automatic load_settings(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                                input logic [NS_W-1:0] ns,
                                input logic [COEF_W-1:0] c4, input logic [COEF_W-1:0] c3,
                                input logic [COEF_W-1:0] c2, input logic [COEF_W-1:0] c1,
                                input logic [COEF_W-1:0] c0);
      write_csr(CSR_IMAGE_WIDTH,  CSR_DATA_W'(w),  DIM_W);
      write_csr(CSR_IMAGE_HEIGHT, CSR_DATA_W'(h),  DIM_W);
      write_csr(CSR_NORM_SCALE,   CSR_DATA_W'(ns), NS_W);
      write_csr(CSR_COEF_R4,      CSR_DATA_W'(c4), COEF_W);
      write_csr(CSR_COEF_R3,      CSR_DATA_W'(c3), COEF_W);
      write_csr(CSR_COEF_R2,      CSR_DATA_W'(c2), COEF_W);
      write_csr(CSR_COEF_R1,      CSR_DATA_W'(c1), COEF_W);
      write_csr(CSR_COEF_R0,      CSR_DATA_W'(c0), COEF_W);
      csr_wr_en <= 1'b0;
   endtask

   // drop valid and let every predicted pixel come back
   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      repeat (2) @(posedge clock);
      while (pending != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [DIM_W-1:0] pick_dim();
      int roll;
      roll = $urandom_range(19);
      if (roll == 0)
         return '0;
      else if (roll < 3)
         return DIM_W'(MAX_DIM);
      else if (roll == 3)
         return DIM_W'($urandom_range((1 << DIM_W) - 1, MAX_DIM + 1));
      else if (roll < 12)
         return DIM_W'($urandom_range(64, 1));
      return DIM_W'($urandom_range(MAX_DIM, 1));
   endfunction

   function automatic logic [COEF_W-1:0] pick_coef();
      int roll;
      roll = $urandom_range(9);
      if (roll < 6)
         return COEF_W'($urandom_range(32768, 0) - 16384);
      else if (roll == 6)
         return COEF_W'($urandom);
      else if (roll == 7)
         return COEF_W'($urandom_range(2048, 0) - 1024);
      else if (roll == 8)
         return COEF_ONE;
      return COEF_NEG_ONE;
   endfunction

   // random settings, then a burst of pixels mostly inside the frame
   task automatic random_phase(input int count);
      logic [DIM_W-1:0]  w, h;
      logic [NS_W-1:0]   ns;
      logic [COEF_W-1:0] c0;
      logic [COL_W-1:0]  col, row;
      int                weff, heff, roll;
      w = pick_dim();
      h = pick_dim();
      weff = (w > MAX_DIM) ? MAX_DIM : int'(w);
      heff = (h > MAX_DIM) ? MAX_DIM : int'(h);
      roll = $urandom_range(9);
      if (roll < 6)
         ns = (weff + heff == 0) ? RST_NORM : NS_W'(NS_SPAN / (weff + heff));
      else if (roll < 8)
         ns = NS_W'($urandom_range(NS_SPAN, 0));
      else if (roll == 8)
         ns = '1;
      else
         ns = NS_W'($urandom_range(255, 0));
      // constant term near unity half the time, like a real lens profile
      if ($urandom_range(1))
         c0 = COEF_ONE - COEF_W'($urandom_range(1024, 0));
      else
         c0 = pick_coef();
      load_settings(w, h, ns, pick_coef(), pick_coef(), pick_coef(), pick_coef(), c0);
      repeat (count) begin
         roll = $urandom_range(99);
         if (roll < 15 && weff > 0 && heff > 0) begin
            col = COL_W'(weff - 1);
            row = COL_W'(heff - 1);
         end else if (roll < 70 && weff > 0 && heff > 0) begin
            col = COL_W'($urandom_range(weff - 1, 0));
            row = COL_W'($urandom_range(heff - 1, 0));
         end else begin
            col = COL_W'($urandom);
            row = COL_W'($urandom);
         end
         send_pixel(col, row, PIX_W'($urandom), PIX_W'($urandom), PIX_W'($urandom));
      end
      wait_idle();
   endtask

   initial begin
      reset         = 1'b1;
      steady        = 1'b0;
      csr_wr_en     = 1'b0;
      csr_index     = CSR_IMAGE_WIDTH;
      csr_wdata     = '0;
      req_ch.valid  = 1'b0;
      req_ch.column = '0;
      req_ch.row    = '0;
      req_ch.red    = '0;
      req_ch.green  = '0;
      req_ch.blue   = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset settings: unity gain, 100x100 frame
      send_pixel(12'd0,    12'd0,    8'd255, 8'd255, 8'd255);
      send_pixel(12'd50,   12'd50,   8'd0,   8'd128, 8'd255);
      send_pixel(12'd99,   12'd99,   8'd1,   8'd2,   8'd3);
      send_pixel(12'd99,   12'd98,   8'd10,  8'd20,  8'd30);
      send_pixel(12'd98,   12'd99,   8'd40,  8'd50,  8'd60);
      send_pixel(12'd4095, 12'd4095, 8'd255, 8'd0,   8'd170);
      send_pixel(12'd0,    12'd4095, 8'd85,  8'd255, 8'd0);
      send_pixel(12'd4095, 12'd0,    8'd128, 8'd64,  8'd32);
      wait_idle();

      // one-pixel frame, full scale: radius saturates and the gain clamps
      load_settings(13'd1, 13'd1, '1, COEF_ONE, COEF_NEG_ONE, COEF_ONE, COEF_ONE, COEF_ONE);
      send_pixel(12'd0,    12'd0,    8'd100, 8'd1,   8'd255);
      send_pixel(12'd1,    12'd0,    8'd0,   8'd17,  8'd200);
      send_pixel(12'd4095, 12'd4095, 8'd255, 8'd128, 8'd1);
      wait_idle();

      // zero-sized frame with a negative gain everywhere
      load_settings('0, '0, 24'd1, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000);
      send_pixel(12'd0,    12'd0,    8'd255, 8'd255, 8'd255);
      send_pixel(12'd4095, 12'd4095, 8'd255, 8'd128, 8'd1);
      send_pixel(12'd2048, 12'd1,    8'd9,   8'd99,  8'd199);
      wait_idle();

      // oversized frame held at the limit, zero scale leaves only the constant term
      load_settings('1, '1, '0, COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ONE);
      send_pixel(12'd4095, 12'd4095, 8'd77,  8'd255, 8'd0);
      send_pixel(12'd2048, 12'd2048, 8'd1,   8'd2,   8'd4);
      send_pixel(12'd0,    12'd0,    8'd254, 8'd127, 8'd63);
      send_pixel(12'd4095, 12'd4094, 8'd8,   8'd16,  8'd32);
      wait_idle();

      // random settings, one phase streaming without any idling
      for (int p = 0; p < PHASES; p++) begin
         steady = (p == STEADY_PHASE);
         random_phase(RANDOM_PIXELS / PHASES);
      end
      steady = 1'b0;

      repeat (PIPE_DEPTH + 10) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("tb_radial_vignetting_gain_top OK");
      else
         $display("tb_radial_vignetting_gain_top NOT OK");
      $finish;
   end

endmodule

FILE: sim.f
design/rvg_pkg.sv
design/rvg_if.sv
design/rvg_sqrt.sv
design/radial_vignetting_gain_top.sv
design/rvg_checker.sv
verif/rvg_pixel_checker.sv
verif/tb_radial_vignetting_gain_top.sv
